### rtl/core/hpe_pkg.sv
// Package for the Horner polynomial evaluator: item types, action codes and
// configuration register indexes. No dependencies.
package hpe_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned LEN_REG_W = 9;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 1'b1;

	typedef struct packed {
		logic              action;
		logic [7:0]        coeff_index;
		logic [WORD_W-1:0] operand;
		logic              last_point;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              last_result;
	} out_item_t;

endpackage

### rtl/core/horner_poly_eval_mod_n_unit.sv
// Top level of the Horner polynomial evaluator modulo a configured modulus.
// Uses hpe_pkg, hpe_ram and hpe_modstep.
//
// A load item writes one coefficient in the cycle it is accepted; busy stays
// low. An evaluate item with a nonzero length holds busy until its result
// strobe. Length zero gives its result in the cycle after acceptance. For
// length one or a zero point the item passes the read wait and coefficient
// load states. Otherwise one modular step unit does all the work, one double
// or add per cycle: it reduces the point if it is not below the modulus and
// each coefficient not below it, then multiplies and adds. The multiply
// is a bit-serial double-and-add over the 64 bits of the reduced point.
// The result strobe lasts one cycle and cannot be held off.
module horner_poly_eval_mod_n_unit #(
	parameter int unsigned MAX_LENGTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  hpe_pkg::in_item_t             item,
	output logic                          result_valid,
	output hpe_pkg::out_item_t            result,
	input  logic                          cfg_we,
	input  logic [hpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hpe_pkg::WORD_W-1:0]    cfg_data
);
	import hpe_pkg::*;

	localparam int unsigned AW  = $clog2(MAX_LENGTH);
	localparam int unsigned LW  = $clog2(MAX_LENGTH + 1);
	localparam int unsigned CW  = (LW > LEN_REG_W) ? LW : LEN_REG_W;
	localparam int unsigned BCW = $clog2(WORD_W);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_XRED  = 9'b000000010,
		S_RWAIT = 9'b000000100,
		S_CLOAD = 9'b000001000,
		S_CRED  = 9'b000010000,
		S_MDBL  = 9'b000100000,
		S_MADD  = 9'b001000000,
		S_CADD  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [WORD_W-1:0]    modulus_q;
	logic [LEN_REG_W-1:0] length_q;
	logic                 top_q;
	logic                 simple_q;
	logic                 res_valid_q;
	logic [WORD_W-1:0]    res_value_q;
	logic                 last_q;
	logic [WORD_W-1:0]    acc_q;
	logic [WORD_W-1:0]    prod_q;
	logic [WORD_W-1:0]    xr_q;
	logic [WORD_W-1:0]    cr_q;
	logic [WORD_W-1:0]    opnd_q;
	logic [BCW-1:0]       cnt_q;
	logic [AW-1:0]        idx_q;

	logic [WORD_W:0]   n_mod;
	logic [CW-1:0]     len_ext;
	logic [CW-1:0]     len_sat;
	logic [CW-1:0]     idx_ext;
	logic              accept;
	logic              ram_we;
	logic [WORD_W-1:0] rdata;
	logic              rdata_lt;
	logic              x_lt;
	logic [WORD_W-1:0] step_r;
	logic [WORD_W-1:0] step_add;
	logic              step_dbl;
	logic [WORD_W-1:0] step_res;

	assign n_mod    = (modulus_q == '0) ? {1'b1, {WORD_W{1'b0}}} : {1'b0, modulus_q};
	assign len_ext  = CW'(length_q);
	assign len_sat  = (len_ext > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : len_ext;
	assign idx_ext  = CW'(item.coeff_index);
	assign accept   = start && (state_q == S_IDLE);
	assign ram_we   = accept && (item.action == ACT_LOAD) && (idx_ext < CW'(MAX_LENGTH));
	assign rdata_lt = {1'b0, rdata} < n_mod;
	assign x_lt     = {1'b0, item.operand} < n_mod;

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = '{value: res_value_q, last_result: last_q};

	hpe_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_LENGTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(idx_ext)),
		.wdata(item.operand),
		.raddr(idx_q),
		.rdata(rdata)
	);

	// Operand selection for the shared step unit.
	always_comb begin
		step_r   = acc_q;
		step_add = '0;
		step_dbl = 1'b0;
		case (state_q)
			S_XRED: begin
				step_r   = xr_q;
				step_add = WORD_W'(opnd_q[cnt_q]);
				step_dbl = 1'b1;
			end
			S_CRED: begin
				step_r   = top_q ? acc_q : cr_q;
				step_add = WORD_W'(opnd_q[cnt_q]);
				step_dbl = 1'b1;
			end
			S_MDBL: begin
				step_r   = prod_q;
				step_dbl = 1'b1;
			end
			S_MADD: begin
				step_r   = prod_q;
				step_add = acc_q;
			end
			S_CADD: begin
				step_r   = acc_q;
				step_add = cr_q;
			end
			default: begin
				step_r = acc_q;
			end
		endcase
	end

	hpe_modstep u_step (
		.r     (step_r),
		.addend(step_add),
		.dbl   (step_dbl),
		.n_mod (n_mod),
		.res   (step_res)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_W'(1);
			length_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULUS: modulus_q <= cfg_data;
				CFG_LENGTH:  length_q  <= cfg_data[LEN_REG_W-1:0];
				default:     modulus_q <= modulus_q;
			endcase
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			top_q       <= 1'b0;
			simple_q    <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && item.action == ACT_EVAL) begin
						top_q    <= 1'b1;
						simple_q <= (len_sat == CW'(1)) || (item.operand == '0);
						if (len_sat == '0) begin
							res_valid_q <= 1'b1;
						end else if ((len_sat == CW'(1)) || (item.operand == '0) || x_lt) begin
							state_q <= S_RWAIT;
						end else begin
							state_q <= S_XRED;
						end
					end
				end
				S_XRED: begin
					if (cnt_q == '0) begin
						state_q <= S_RWAIT;
					end
				end
				S_RWAIT: state_q <= S_CLOAD;
				S_CLOAD: begin
					if (simple_q) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b1;
					end else if (!rdata_lt) begin
						state_q <= S_CRED;
					end else begin
						state_q <= top_q ? S_MDBL : S_CADD;
					end
				end
				S_CRED: begin
					if (cnt_q == '0) begin
						state_q <= top_q ? S_MDBL : S_CADD;
					end
				end
				S_MDBL: state_q <= S_MADD;
				S_MADD: begin
					if (cnt_q == '0) begin
						top_q   <= 1'b0;
						state_q <= S_RWAIT;
					end else begin
						state_q <= S_MDBL;
					end
				end
				S_CADD: begin
					state_q <= (idx_q == '0) ? S_DONE : S_MDBL;
				end
				S_DONE: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && item.action == ACT_EVAL) begin
					last_q      <= item.last_point;
					opnd_q      <= item.operand;
					res_value_q <= '0;
					cnt_q       <= BCW'(WORD_W - 1);
					if ((len_sat == CW'(1)) || (item.operand == '0)) begin
						idx_q <= '0;
					end else begin
						idx_q <= AW'(len_sat - CW'(1));
					end
					xr_q <= x_lt ? item.operand : '0;
				end
			end
			S_XRED: begin
				xr_q  <= step_res;
				cnt_q <= cnt_q - BCW'(1);
			end
			S_CLOAD: begin
				cnt_q  <= BCW'(WORD_W - 1);
				prod_q <= '0;
				if (simple_q) begin
					res_value_q <= rdata;
				end else if (!rdata_lt) begin
					opnd_q <= rdata;
					if (top_q) begin
						acc_q <= '0;
					end else begin
						cr_q <= '0;
					end
				end else if (top_q) begin
					acc_q <= rdata;
				end else begin
					cr_q <= rdata;
				end
			end
			S_CRED: begin
				if (top_q) begin
					acc_q <= step_res;
				end else begin
					cr_q <= step_res;
				end
				if (cnt_q == '0) begin
					cnt_q  <= BCW'(WORD_W - 1);
					prod_q <= '0;
				end else begin
					cnt_q <= cnt_q - BCW'(1);
				end
			end
			S_MDBL: prod_q <= step_res;
			S_MADD: begin
				if (xr_q[cnt_q]) begin
					prod_q <= step_res;
				end
				if (cnt_q == '0) begin
					acc_q <= xr_q[cnt_q] ? step_res : prod_q;
					idx_q <= idx_q - AW'(1);
				end else begin
					cnt_q <= cnt_q - BCW'(1);
				end
			end
			S_CADD: begin
				acc_q       <= step_res;
				res_value_q <= step_res;
				prod_q      <= '0;
				cnt_q       <= BCW'(WORD_W - 1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A result strobe follows either an accepted item or busy work.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(busy) || $past(start)))
		else $error("result strobe without a preceding item");

	// A load item never occupies the sequencer.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_LOAD) |=> !busy)
		else $error("load item made the block busy");

	// An evaluation with a nonzero length always enters the sequencer.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ACT_EVAL && length_q != '0) |=> busy)
		else $error("evaluation did not start");

	// The multiply loop only ever sees reduced operands.
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MDBL) |-> (({1'b0, acc_q} < n_mod) && ({1'b0, xr_q} < n_mod)))
		else $error("multiply operand not reduced");
`endif

endmodule

### rtl/core/hpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hpe_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/hpe_modstep.sv
// Shared modular step: (r or 2r) + addend, reduced once against the modulus.
// Uses hpe_pkg. Requires r and addend below the modulus.
module hpe_modstep (
	input  logic [hpe_pkg::WORD_W-1:0] r,
	input  logic [hpe_pkg::WORD_W-1:0] addend,
	input  logic                       dbl,
	input  logic [hpe_pkg::WORD_W:0]   n_mod,
	output logic [hpe_pkg::WORD_W-1:0] res
);
	import hpe_pkg::*;

	logic [WORD_W:0] base;
	logic [WORD_W:0] sum;
	logic [WORD_W:0] diff;

	always_comb begin
		base = dbl ? {r, 1'b0} : {1'b0, r};
		sum  = base + {1'b0, addend};
		diff = sum - n_mod;
		res  = (sum >= n_mod) ? diff[WORD_W-1:0] : sum[WORD_W-1:0];
	end
endmodule

### test/tb.sv
// Testbench for horner_poly_eval_mod_n_unit: loads coefficient sets, evaluates points and checks
// each result against a Horner predictor over several modulus and length settings.
// Depends on hpe_pkg and the RTL of the unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hpe_pkg::*;

	localparam int unsigned STORE_DEPTH = 256;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_item_t             item;
	logic                 result_valid;
	out_item_t            result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	horner_poly_eval_mod_n_unit #(.MAX_LENGTH(STORE_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: its own copy of the registers and the coefficient store.
	logic [63:0] coef_store [STORE_DEPTH];
	logic [63:0] cur_modulus;
	logic [8:0]  cur_length;

	in_item_t  item_queue [$];
	out_item_t poly_values [$];
	int        sent_count;
	int        eval_count;
	int        load_count;
	int        result_count;
	int        mismatch_count;
	int        phase_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// A modulus of zero stands for 2^64, so the arithmetic simply wraps.
	function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] n);
		logic [127:0] prod;
		if (n == 64'd0)
			return a * b;
		prod = {64'b0, a} * {64'b0, b};
		return 64'(prod % {64'b0, n});
	endfunction

	function automatic logic [63:0] mod_add_coef(logic [63:0] acc, logic [63:0] c,
			logic [63:0] n);
		logic [64:0] sum;
		if (n == 64'd0)
			return acc + c;
		sum = {1'b0, acc} + {1'b0, c % n};
		return 64'(sum % {1'b0, n});
	endfunction

	function automatic logic [63:0] horner_value(logic [63:0] x);
		int          len;
		logic [63:0] acc;
		len = (cur_length > STORE_DEPTH) ? STORE_DEPTH : int'(cur_length);
		if (len == 0)
			return 64'd0;
		if (len == 1 || x == 64'd0)
			return coef_store[0];
		acc = coef_store[len-1];
		for (int i = len - 1; i > 0; i--) begin
			acc = mod_mul(acc, x, cur_modulus);
			acc = mod_add_coef(acc, coef_store[i-1], cur_modulus);
		end
		return acc;
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t make_item(logic act, logic [7:0] idx, logic [63:0] op,
			logic last);
		in_item_t it;
		it.action      = act;
		it.coeff_index = idx;
		it.operand     = op;
		it.last_point  = last;
		return it;
	endfunction

	// The sender pauses at random, except over a stretch in the middle of the run.
	function automatic bit sender_idles();
		if (sent_count >= 500 && sent_count < 750)
			return 1'b0;
		return $urandom_range(99) < 17;
	endfunction

	always @(posedge clk) begin
		if (arst_n && (!start || !busy)) begin
			if (item_queue.size() > 0 && !sender_idles()) begin
				start <= 1'b1;
				item  <= item_queue.pop_front();
				sent_count++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (start && !busy) begin
				if (item.action == ACT_LOAD) begin
					coef_store[item.coeff_index] = item.operand;
					load_count++;
				end else begin
					want.value       = horner_value(item.operand);
					want.last_result = item.last_point;
					poly_values.push_back(want);
					eval_count++;
				end
			end
			if (result_valid) begin
				result_count++;
				if (poly_values.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: value %h last %b", result.value,
							result.last_result);
				end else begin
					want = poly_values.pop_front();
					if (result.value !== want.value || result.last_result !== want.last_result) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch on result %0d: expected value %h last %b, got value %h last %b",
								result_count, want.value, want.last_result, result.value,
								result.last_result);
					end
				end
			end
		end
	end

	// Waits until every queued item has gone in and every result has come back.
	task automatic settle();
		do
			@(posedge clk);
		while (item_queue.size() != 0 || start || poly_values.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == CFG_MODULUS)
			cur_modulus = data;
		else
			cur_length = data[8:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_phase(logic [63:0] n, logic [8:0] len);
		write_reg(CFG_MODULUS, n);
		write_reg(CFG_LENGTH, {55'b0, len});
		phase_count++;
	endtask

	function automatic logic [63:0] pick_coef();
		if ($urandom_range(99) < 80)
			return rand_word() % cur_modulus;
		return rand_word();
	endfunction

	function automatic logic [63:0] pick_point();
		case ($urandom_range(7))
			0:       return 64'd0;
			1:       return ALL_ONES;
			2, 3:    return 64'($urandom_range(1000));
			default: return rand_word();
		endcase
	endfunction

	initial begin
		logic [63:0] n;
		logic [8:0]  len;
		int          count;
		int          roll;
		start          = 1'b0;
		item           = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		cur_modulus    = 64'd1;
		cur_length     = 9'd0;
		sent_count     = 0;
		eval_count     = 0;
		load_count     = 0;
		result_count   = 0;
		mismatch_count = 0;
		phase_count    = 0;
		arst_n         = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: length zero always gives zero.
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, 64'd0, 1'b0));
		item_queue.push_back(make_item(ACT_EVAL, 8'hFF, ALL_ONES, 1'b1));
		settle();

		// Length one returns coefficient 0 unreduced, even when it equals the modulus.
		set_phase(ALL_ONES, 9'd1);
		item_queue.push_back(make_item(ACT_LOAD, 8'd0, ALL_ONES, 1'b1));
		item_queue.push_back(make_item(ACT_LOAD, 8'd255, 64'h5555_5555_5555_5555, 1'b0));
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, 64'd7, 1'b0));
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, 64'd0, 1'b1));
		settle();

		// Full Horner path with an unreduced coefficient 0 and a point at the top of the range.
		set_phase(ALL_ONES, 9'd3);
		item_queue.push_back(make_item(ACT_LOAD, 8'd1, ALL_ONES - 1, 1'b0));
		item_queue.push_back(make_item(ACT_LOAD, 8'd2, 64'h8000_0000_0000_0000, 1'b0));
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, ALL_ONES, 1'b0));
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, 64'd1, 1'b0));
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, 64'd0, 1'b1));
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, 64'd2, 1'b0));
		settle();

		set_phase(64'd1, 9'd2);
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, 64'd3, 1'b1));
		settle();

		set_phase(ALL_ONES - 58, 9'd3);
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, ALL_ONES - 60, 1'b0));
		item_queue.push_back(make_item(ACT_EVAL, 8'd0, ALL_ONES - 58, 1'b1));
		settle();

		for (int ph = 0; ph < 14; ph++) begin
			case (ph % 5)
				0:       n = rand_word() | 64'd1;
				1:       n = 64'($urandom_range(1000, 1));
				2:       n = ALL_ONES;
				3:       n = 64'($urandom_range(2, 1));
				default: n = {1'b1, rand_word() >> 1};
			endcase
			len = (ph == 7) ? 9'd256 : 9'($urandom_range(6));
			set_phase(n, len);
			// Every coefficient in use is written before the first evaluation.
			for (int i = 0; i < int'(len); i++)
				item_queue.push_back(make_item(ACT_LOAD, 8'(i), pick_coef(), $urandom_range(1)));
			count = (ph == 7) ? 2 : 80;
			for (int k = 0; k < count; k++) begin
				roll = (ph == 7) ? 0 : $urandom_range(99);
				if (roll < 65)
					item_queue.push_back(make_item(ACT_EVAL, 8'($urandom), pick_point(),
						$urandom_range(1)));
				else if (roll < 90 && len != 0)
					item_queue.push_back(make_item(ACT_LOAD, 8'($urandom_range(int'(len) - 1)),
						pick_coef(), $urandom_range(1)));
				else
					item_queue.push_back(make_item(ACT_LOAD, 8'($urandom), rand_word(),
						$urandom_range(1)));
			end
			settle();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d settings: %0d loads, %0d evaluations, %0d results checked",
			phase_count, load_count, eval_count, result_count);
		$display("%0d mismatches, %0d results still outstanding", mismatch_count,
			poly_values.size());
		if (mismatch_count == 0 && poly_values.size() == 0)
			$display("[horner_poly_eval_mod_n_unit] OK");
		else
			$display("[horner_poly_eval_mod_n_unit] ERROR");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("timeout with %0d results outstanding", poly_values.size());
		$display("[horner_poly_eval_mod_n_unit] ERROR");
		$finish;
	end

endmodule
